@@ rtl/core/gchd_pkg.sv @@
// ----------------------------------------------------------------------------
// gchd_pkg
// Shared types and constants for the object header decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gchd_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OFF_W   = 9;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CNT_LSB = 3;

  // Header kinds as reported on the result channel
  typedef enum logic [KIND_W-1:0] {
    KIND_FMT    = 2'd0,
    KIND_FWD    = 2'd1,
    KIND_RAW    = 2'd2,
    KIND_LAYOUT = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  // Classified header, before any layout walk
  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  value;
    logic               walk;   // layout with at least one pointer slot
  } hdr_dec_t;

  // Status of the layout walker for the current slot
  typedef struct packed {
    logic              cur_bit;  // slot under the walker holds a pointer
    logic              more;     // further pointer slots remain
    logic [OFF_W-1:0]  aligned;  // offset of this slot when it is a pointer
  } walk_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/gchd_classify.sv @@
// ----------------------------------------------------------------------------
// gchd_classify
// Tag decode of one header word, slot count clamp and layout slot mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gchd_classify
  import gchd_pkg::*;
#(
  parameter int unsigned LAYOUT_BITS = 55
) (
  input  wire logic [WORD_W-1:0]      header_word,
  output      hdr_dec_t               dec,
  output      logic [LAYOUT_BITS-1:0] slots
);

  logic [CNT_W-1:0]       cnt_raw;
  logic [CNT_W-1:0]       cnt;
  logic [LAYOUT_BITS-1:0] keep;

  // Slot count from bits 3..8, clamped to the layout capacity
  assign cnt_raw = header_word[CNT_LSB +: CNT_W];
  assign cnt     = (cnt_raw > CNT_W'(LAYOUT_BITS)) ? CNT_W'(LAYOUT_BITS) : cnt_raw;

  // Keep only the top cnt slot bits, walked from bit 63 down
  assign keep  = ~({LAYOUT_BITS{1'b1}} >> cnt);
  assign slots = header_word[WORD_W-1 -: LAYOUT_BITS] & keep;

  // Tag decode; bit 0 clear gives format string, whatever bits 1 and 2 hold
  always_comb begin
    dec.walk = 1'b0;
    if (!header_word[0]) begin
      dec.kind  = KIND_FMT;
      dec.value = header_word;
    end else if (!header_word[1]) begin
      dec.kind  = KIND_FWD;
      dec.value = {header_word[WORD_W-1:1], 1'b0};
    end else if (!header_word[2]) begin
      dec.kind  = KIND_RAW;
      dec.value = header_word >> 3;
    end else begin
      dec.kind  = KIND_LAYOUT;
      dec.value = {{(WORD_W-CNT_W-3){1'b0}}, cnt, 3'b000};
      dec.walk  = |slots;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gchd_walk.sv @@
// ----------------------------------------------------------------------------
// gchd_walk
// Layout walker: slot shift register and running byte offset unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gchd_walk
  import gchd_pkg::*;
#(
  parameter int unsigned LAYOUT_BITS = 55
) (
  input  wire logic                   clk,
  input  wire logic                   load,
  input  wire logic [LAYOUT_BITS-1:0] slots_in,
  input  wire logic                   step,
  output      walk_stat_t             stat
);

  logic [LAYOUT_BITS-1:0] slots;
  logic [LAYOUT_BITS-1:0] rest;
  logic [OFF_W-1:0]       offset;
  logic [OFF_W-1:0]       offset_next;

  assign rest         = slots << 1;
  assign stat.cur_bit = slots[LAYOUT_BITS-1];
  assign stat.more    = |rest;

  // Offset is always a multiple of 4; a pointer aligns it up to 8
  assign stat.aligned = offset[2] ? offset + OFF_W'(4) : offset;
  assign offset_next  = stat.cur_bit ? stat.aligned + OFF_W'(8) : offset + OFF_W'(4);

  // Walk state: payload only, reloaded on every accepted header word
  always_ff @(posedge clk) begin
    if (load) begin
      slots  <= slots_in;
      offset <= '0;
    end else if (step) begin
      slots  <= rest;
      offset <= offset_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gc_header_decode_offsets.sv @@
// ----------------------------------------------------------------------------
// gc_header_decode_offsets
// Object header decoder with struct layout pointer offset walk.
// ----------------------------------------------------------------------------
// Input channel: header_word with header_valid / header_stall. Output
// channel: header_kind, header_value, has_offset, pointer_offset, last with
// result_valid / result_stall. A word moves when valid is high and stall low.
// Format string, forwarding and raw headers, and layouts without pointer
// slots, give one result word, registered in the cycle after acceptance.
// A layout header is walked one slot per cycle while the result side does
// not stall, from bit 63 down by a single offset unit; the walk stops at
// the last pointer slot. One result word is given per pointer slot, the
// final one marked with last. A new header is taken only once the walk is
// over. A stall on the result side holds the output register and freezes
// the walk. Reset (rst, synchronous) empties the output register and
// returns the sequencer to idle; the input is stalled while rst is high.
// No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gc_header_decode_offsets
  import gchd_pkg::*;
#(
  parameter int unsigned LAYOUT_BITS = 55
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [WORD_W-1:0]  header_word,
  input  wire logic               header_valid,
  output      logic               header_stall,
  output      logic [KIND_W-1:0]  header_kind,
  output      logic [WORD_W-1:0]  header_value,
  output      logic               has_offset,
  output      logic [OFF_W-1:0]   pointer_offset,
  output      logic               last,
  output      logic               result_valid,
  input  wire logic               result_stall
);

  state_t                 state;
  state_t                 state_next;
  hdr_dec_t               dec;
  logic [LAYOUT_BITS-1:0] slots;
  walk_stat_t             stat;
  logic [WORD_W-1:0]      size;
  logic                   out_free;
  logic                   in_acc;
  logic                   walk_step;
  logic                   emit_direct;
  logic                   emit_ptr;

  gchd_classify #(.LAYOUT_BITS(LAYOUT_BITS)) u_classify (
    .header_word (header_word),
    .dec         (dec),
    .slots       (slots)
  );

  gchd_walk #(.LAYOUT_BITS(LAYOUT_BITS)) u_walk (
    .clk      (clk),
    .load     (in_acc),
    .slots_in (slots),
    .step     (walk_step),
    .stat     (stat)
  );

  assign out_free = !result_valid || !result_stall;
  assign in_acc   = header_valid && !header_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && dec.walk) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (out_free && stat.cur_bit && !stat.more) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    header_stall = 1'b1;
    walk_step    = 1'b0;
    case (state)
      ST_IDLE: header_stall = rst || !out_free;
      ST_WALK: walk_step    = out_free;
      default: header_stall = 1'b1;
    endcase
  end

  assign emit_direct = in_acc && !dec.walk;
  assign emit_ptr    = walk_step && stat.cur_bit;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_direct || emit_ptr) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Layout size held for the walk; result word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      size <= dec.value;
    end
    if (emit_direct) begin
      header_kind    <= dec.kind;
      header_value   <= dec.value;
      has_offset     <= 1'b0;
      pointer_offset <= '0;
      last           <= 1'b1;
    end else if (emit_ptr) begin
      header_kind    <= KIND_LAYOUT;
      header_value   <= size;
      has_offset     <= 1'b1;
      pointer_offset <= stat.aligned;
      last           <= !stat.more;
    end
  end

endmodule

`default_nettype wire
